### src/kst_pkg.sv
`default_nettype none

package kst_pkg;

  // table geometry
  localparam int SLOTS   = 64;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // field widths
  localparam int ACT_W    = 2;
  localparam int KEY_W    = 31;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_PRESENT   = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_RANGE     = 3'd4,
    STATUS_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDREQ,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic scan_en;
    logic rd_issue;
    logic load;
  } kst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } kst_sts_t;

endpackage

`default_nettype wire

### src/keyed_slot_table_allocator_unit.sv
// keyed slot table allocator: a table of SLOTS key slots with valid bits
// input channel (in_valid / in_stall): one request carries in_action,
//   in_key and in_slot_index; insert puts the key in the lowest free slot
//   unless it is already present, remove frees the lowest slot holding the
//   key, read returns the key of slot in_slot_index
// result channel (out_valid / out_stall): one result per request with
//   status, slot, key_out and the free and used counts after the request
// sequence: insert and remove walk every slot through the single read port of
//   the key ram, one slot per cycle, before the result is loaded; a read
//   issues one ram read first, and an unknown action code goes straight to
//   the result load; one request is in flight at a time, and the next one
//   is taken the cycle after the result is loaded
// stall: a finished result waits in the output register while the next
//   request is accepted and worked on; that request then waits for the
//   register to drain before its result is loaded
// reset: synchronous rst_n clears all valid bits at once (table empty, free
//   count SLOTS); key storage is not cleared and needs no clearing pass
`default_nettype none

module keyed_slot_table_allocator_unit
  import kst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [ACT_W-1:0]    in_action,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [IDX_W-1:0]    in_slot_index,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [IDX_W-1:0]         out_slot,
  output logic [KEY_W-1:0]         out_key_out,
  output logic [COUNT_W-1:0]       out_free_count,
  output logic [COUNT_W-1:0]       out_used_count
);

  kst_cmd_t cmd;
  kst_sts_t sts;

  // sequencer: idle, slot walk, read issue, result load
  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // key ram, valid bits, counters, scan compare and result register
  kst_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_slot_index  (in_slot_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_key_out    (out_key_out),
    .out_free_count (out_free_count),
    .out_used_count (out_used_count)
  );

endmodule

`default_nettype wire

### src/kst_ram.sv
`default_nettype none

module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/kst_ctrl.sv
`default_nettype none

module kst_ctrl
  import kst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [ACT_W-1:0] in_action,
  output logic                  in_stall,
  output kst_cmd_t              cmd,
  input  wire kst_sts_t         sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (action_t'(in_action))
            ACT_INSERT, ACT_REMOVE: state_nxt = S_SCAN;
            ACT_READ:               state_nxt = S_RDREQ;
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_RDREQ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### src/kst_dp.sv
`default_nettype none

module kst_dp
  import kst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kst_cmd_t            cmd,
  output kst_sts_t                 sts,
  input  wire logic [ACT_W-1:0]    in_action,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [IDX_W-1:0]    in_slot_index,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [IDX_W-1:0]         out_slot,
  output logic [KEY_W-1:0]         out_key_out,
  output logic [COUNT_W-1:0]       out_free_count,
  output logic [COUNT_W-1:0]       out_used_count
);

  // captured request
  action_t            act_r;
  logic [KEY_W-1:0]   key_r;
  logic [IDX_W-1:0]   idx_r;

  // scan state
  logic [CNT_W-1:0]   scan_r;
  logic               cmp_vld_r;
  logic               cmp_live_r;
  logic [SLOT_W-1:0]  cmp_idx_r;
  logic               found_r;
  logic [SLOT_W-1:0]  found_idx_r;
  logic               free_hit_r;
  logic [SLOT_W-1:0]  free_idx_r;

  // table state
  logic [SLOTS-1:0]   valid_r;
  logic [COUNT_W-1:0] free_r;

  // result register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [COUNT_W-1:0]  out_free_r;
  logic [COUNT_W-1:0]  out_used_r;

  logic               scan_live;
  logic               scan_issue;
  logic [SLOT_W-1:0]  scan_addr;
  logic [SLOT_W-1:0]  idx_addr;
  logic               idx_in_range;
  logic               key_hit;
  logic [SLOT_W-1:0]  ram_raddr;
  logic               ram_re;
  logic [KEY_W-1:0]   ram_rdata;

  status_t            res_status;
  logic [IDX_W-1:0]   res_slot;
  logic [KEY_W-1:0]   res_key;
  logic [COUNT_W-1:0] free_nxt;
  logic               do_insert;
  logic               do_remove;

  assign scan_live    = (scan_r < CNT_W'(SLOTS));
  assign scan_issue   = cmd.scan_en && scan_live;
  assign scan_addr    = scan_r[SLOT_W-1:0];
  assign idx_addr     = idx_r[SLOT_W-1:0];
  assign idx_in_range = ({1'b0, idx_r} < COUNT_W'(SLOTS));
  assign key_hit      = cmp_vld_r && cmp_live_r && (ram_rdata == key_r);

  assign ram_raddr = cmd.rd_issue ? idx_addr : scan_addr;
  assign ram_re    = scan_issue || cmd.rd_issue;

  kst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.load && do_insert),
    .waddr (free_idx_r),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      key_r <= in_key;
      idx_r <= in_slot_index;
    end
  end

  // sequential scan: duplicate compare in the cycle after the ram read,
  // first free slot picked at issue time from the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r     <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (cmd.capture) begin
      scan_r     <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (cmd.scan_en) begin
      if (scan_live) begin
        scan_r <= scan_r + CNT_W'(1);
      end
      cmp_vld_r <= scan_issue;
      if (scan_issue && !valid_r[scan_addr] && !free_hit_r) begin
        free_hit_r <= 1'b1;
      end
      if (key_hit && !found_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      cmp_idx_r  <= scan_addr;
      cmp_live_r <= valid_r[scan_addr];
      if (scan_issue && !valid_r[scan_addr] && !free_hit_r) begin
        free_idx_r <= scan_addr;
      end
      if (key_hit && !found_r) begin
        found_idx_r <= cmp_idx_r;
      end
    end
  end

  // result and table update
  always_comb begin
    res_status = STATUS_OK;
    res_slot   = '0;
    res_key    = '0;
    free_nxt   = free_r;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    unique case (act_r)
      ACT_INSERT: begin
        if (found_r) begin
          res_status = STATUS_PRESENT;
        end else if (free_hit_r) begin
          res_slot  = IDX_W'(free_idx_r);
          do_insert = 1'b1;
          free_nxt  = free_r - COUNT_W'(1);
        end else begin
          res_status = STATUS_FULL;
        end
      end
      ACT_REMOVE: begin
        if (found_r) begin
          res_slot  = IDX_W'(found_idx_r);
          do_remove = 1'b1;
          free_nxt  = free_r + COUNT_W'(1);
        end else begin
          res_status = STATUS_NOT_FOUND;
        end
      end
      ACT_READ: begin
        res_slot = idx_r;
        if (!idx_in_range) begin
          res_status = STATUS_RANGE;
        end else if (!valid_r[idx_addr]) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_key = ram_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      free_r      <= COUNT_W'(SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (do_insert) begin
          valid_r[free_idx_r] <= 1'b1;
        end
        if (do_remove) begin
          valid_r[found_idx_r] <= 1'b0;
        end
        free_r      <= free_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_key_r    <= res_key;
      out_free_r   <= free_nxt;
      out_used_r   <= COUNT_W'(SLOTS) - free_nxt;
    end
  end

  assign sts.scan_done = !scan_live && !cmp_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_key_out    = out_key_r;
  assign out_free_count = out_free_r;
  assign out_used_count = out_used_r;

`ifndef ASSERT_OFF
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= COUNT_W'(SLOTS))
    else $error("free count above table size");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(free_r) + $countones(valid_r)) == SLOTS)
    else $error("free count disagrees with valid bits");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_valid_r && out_stall))
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

### tb/sv/kst_scoreboard_pkg.sv
`timescale 1ns / 100ps

package kst_scoreboard_pkg;
  import kst_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
    logic [KEY_W-1:0]    key_out;
    logic [COUNT_W-1:0]  free_cnt;
    logic [COUNT_W-1:0]  used_cnt;
  } table_result_t;

  class table_scoreboard;
    bit               occupied[SLOTS];
    logic [KEY_W-1:0] stored[SLOTS];
    int unsigned      free_slots;
    table_result_t    expected_q[$];
    int unsigned      errors;

    function new();
      free_slots = SLOTS;
      errors     = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++) begin
        if (occupied[i] && stored[i] == key) return i;
      end
      return SLOTS;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // update the table copy for one accepted request and queue its result
    function void note_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                               logic [IDX_W-1:0] idx);
      table_result_t r;
      int            hit;
      r.status  = STATUS_OK;
      r.slot    = '0;
      r.key_out = '0;
      case (act)
        ACT_INSERT: begin
          if (find_key(key) < SLOTS) begin
            r.status = STATUS_PRESENT;
          end else begin
            r.status = STATUS_FULL;
            for (int i = 0; i < SLOTS; i++) begin
              if (!occupied[i]) begin
                occupied[i] = 1'b1;
                stored[i]   = key;
                free_slots--;
                r.slot   = IDX_W'(i);
                r.status = STATUS_OK;
                break;
              end
            end
          end
        end
        ACT_REMOVE: begin
          hit = find_key(key);
          if (hit < SLOTS) begin
            occupied[hit] = 1'b0;
            free_slots++;
            r.slot = IDX_W'(hit);
          end else begin
            r.status = STATUS_NOT_FOUND;
          end
        end
        ACT_READ: begin
          r.slot = idx;
          if (idx >= SLOTS) r.status = STATUS_RANGE;
          else if (!occupied[idx]) r.status = STATUS_EMPTY;
          else r.key_out = stored[idx];
        end
        default: ;
      endcase
      r.free_cnt = COUNT_W'(free_slots);
      r.used_cnt = COUNT_W'(SLOTS - free_slots);
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d slot %0d", $time, got.status,
                 got.slot);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("status", want.status, got.status);
      compare("slot", want.slot, got.slot);
      compare("key_out", want.key_out, got.key_out);
      compare("free_count", want.free_cnt, got.free_cnt);
      compare("used_count", want.used_cnt, got.used_cnt);
    endfunction
  endclass

endpackage

### tb/sv/keyed_slot_table_allocator_unit_tb.sv
`timescale 1ns / 100ps

module keyed_slot_table_allocator_unit_tb;
  import kst_pkg::*;
  import kst_scoreboard_pkg::*;

  // the one action code the block treats as a no-op
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam int POOL_SIZE    = 96;        // more keys than slots so the table fills
  localparam int PHASE_LEN    = 150;
  localparam int PHASES       = 6;
  localparam int LIMIT_CYCLES = 1_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ACT_W-1:0]   in_action;
  logic [KEY_W-1:0]   in_key;
  logic [IDX_W-1:0]   in_slot_index;
  logic               out_valid;
  logic               out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]   out_slot;
  logic [KEY_W-1:0]   out_key_out;
  logic [COUNT_W-1:0] out_free_count;
  logic [COUNT_W-1:0] out_used_count;

  table_scoreboard  sb = new();
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  bit               tx_quiet;   // sender never idles
  bit               rx_quiet;   // receiver never stalls
  int unsigned      cycles = 0;

  keyed_slot_table_allocator_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_slot_index  (in_slot_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_key_out    (out_key_out),
    .out_free_count (out_free_count),
    .out_used_count (out_used_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // keys mostly from the pool so duplicates and hits on remove are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, POOL_SIZE-1)];
  endfunction

  // read index: mostly inside the table, now and then past its end
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 255));
    return IDX_W'($urandom_range(0, SLOTS-1));
  endfunction

  // present one request and hold it until the block takes it
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_key        <= key;
    in_slot_index <= idx;
    // stall as seen just before the edge decides acceptance
    do @(posedge clk); while (in_stall);
    sb.note_request(act, key, idx);
  endtask

  // sender holds off until every queued result has come back
  task automatic wait_drained();
    if (sb.outstanding() > 0) begin
      in_valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clk);
    end
  endtask

  // random traffic; fill phases lean on inserts, drain phases on removes
  task automatic run_phase(input int n, input bit filling);
    int               r;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 2) act = ACT_NOP;
      else if (r < 10) act = ACT_READ;
      else if (r < (filling ? 80 : 35)) act = ACT_INSERT;
      else act = ACT_REMOVE;
      // the index field is don't-care except on reads
      if (act == ACT_READ) idx = pick_index();
      else idx = IDX_W'($urandom_range(0, 255));
      send_request(act, pick_key(), idx);
    end
  endtask

  // result side: check every accepted result, stall at random
  initial begin : result_sink
    int unsigned   hold;
    table_result_t got;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.status   = out_status;
        got.slot     = out_slot;
        got.key_out  = out_key_out;
        got.free_cnt = out_free_count;
        got.used_cnt = out_used_count;
        sb.check_result(got);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold = pick_gap(rx_quiet);
      end
    end
  end

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_INSERT;
    in_key        <= '0;
    in_slot_index <= '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    // pool: both key extremes, a run of small keys, the rest random
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i == 0) key_pool[i] = '0;
      else if (i == 1) key_pool[i] = KEY_MAX;
      else if (i < 16) key_pool[i] = KEY_W'(i);
      else key_pool[i] = KEY_W'($urandom);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range checks on an empty table, then the basic cases
    send_request(ACT_READ, '0, IDX_W'(SLOTS));        // first index past the table
    send_request(ACT_READ, KEY_MAX, 8'hFF);           // highest index
    send_request(ACT_NOP, KEY_MAX, 8'hFF);            // unused action code
    send_request(ACT_INSERT, '0, '0);                 // lowest key into slot 0
    send_request(ACT_INSERT, KEY_MAX, 8'hAA);         // highest key into slot 1
    send_request(ACT_INSERT, '0, 8'h55);              // duplicate rejected
    send_request(ACT_READ, '0, 8'd0);
    send_request(ACT_READ, '0, 8'd1);
    send_request(ACT_REMOVE, '0, 8'hFF);              // frees slot 0
    send_request(ACT_READ, KEY_MAX, 8'd0);            // slot now empty
    send_request(ACT_REMOVE, '0, '0);                 // key gone
    send_request(ACT_INSERT, 31'h5555_5555, '0);      // reuses lowest free slot
    send_request(ACT_REMOVE, KEY_MAX, '0);
    send_request(ACT_INSERT, 31'h2AAA_AAAA, '0);
    send_request(ACT_READ, '0, 8'd1);
    send_request(ACT_REMOVE, 31'd12345, 8'd7);        // never inserted
    send_request(ACT_NOP, '0, '0);
    wait_drained();

    // random phases: one with neither side idling, one with only the receiver never stalling
    for (int p = 0; p < PHASES; p++) begin
      tx_quiet = (p == 2);
      rx_quiet = (p == 2) || (p == 4);
      run_phase(PHASE_LEN, (p % 2) == 0);
      if ((p % 2) == 1) wait_drained();
    end

    // let the last result drain, then a margin for anything stray
    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
